// File: hw/rtl/dmq_pkg.sv
package dmq_pkg;

   // Digest geometry: four little-endian 64-bit words, low DIGEST_BITS kept.
   localparam int DIGEST_BITS  = 256;
   localparam int DIGEST_WORDS = 4;
   localparam int WORD_BITS    = 64;

   localparam logic [7:0] WD_MAX = 8'hFF;

   typedef logic [DIGEST_WORDS-1:0][WORD_BITS-1:0] digest_type;

   typedef enum logic [2:0] {
      OP_HOST_FRAME  = 3'd0,
      OP_MAINT_BEGIN = 3'd1,
      OP_MAINT_END   = 3'd2,
      OP_ANIM_START  = 3'd3,
      OP_ANIM_STOP   = 3'd4,
      OP_FAIL        = 3'd5,
      OP_REINSTALLED = 3'd6,
      OP_RESTORE_Q   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      MODE_HOST     = 2'd0,
      MODE_MAINT    = 2'd1,
      MODE_ANIM     = 2'd2,
      MODE_FALLBACK = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CODE_OK      = 3'd0,
      CODE_QUAR    = 3'd1,
      CODE_INVALID = 3'd2,
      CODE_WDOG    = 3'd3,
      CODE_RENDER  = 3'd4
   } code_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] digest_w0;
      logic [63:0] digest_w1;
      logic [63:0] digest_w2;
      logic [63:0] digest_w3;
      logic [1:0]  asset_kind;
      logic        is_watchdog;
   } req_type;

   typedef struct packed {
      logic        accepted;
      mode_type    mode_now;
      logic [1:0]  kind_now;
      logic        is_quarantined;
      logic [7:0]  watchdog_total;
      code_type    result_code;
   } rsp_type;

   // Keep only the digest bits that fall below DIGEST_BITS in word w.
   function automatic logic [WORD_BITS-1:0] word_mask(input int w);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         m[b] = ((WORD_BITS * w + b) < DIGEST_BITS);
      end
      return m;
   endfunction

endpackage

// File: hw/rtl/display_mode_quarantine_fsm.sv
// Flow: an accepted request is captured in the input register; its response is
//   loaded into the response register once that register is empty or its
//   response is taken, and rsp_* show the response register.
// Throughput: one request per cycle while rsp_ready is held high; the state
//   update and the parallel digest compare sit between the two registers.
// Reset (synchronous, active high): startup fallback mode, nothing quarantined,
//   watchdog count zero, last code ok, both pipeline registers empty.
module display_mode_quarantine_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dmq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dmq_pkg::rsp_type rsp_payload
);

   // Input register stage.
   logic             s1_valid_ff, s1_valid_in;
   dmq_pkg::req_type s1_req_ff, s1_req_in;

   // Response register stage.
   logic             rsp_valid_ff, rsp_valid_in;
   dmq_pkg::rsp_type rsp_ff;
   dmq_pkg::rsp_type rsp_next;

   logic advance;
   logic step;
   logic req_take;

   // The response register frees up when empty or when its response is taken.
   assign advance   = !rsp_valid_ff || rsp_ready;
   // Take a new request whenever the input stage is empty or will drain this cycle.
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   // Commit the held request to the supervisor state and the response register.
   assign step      = s1_valid_ff && advance;

   // Drop digest bits above the configured digest width on capture.
   always_comb begin
      s1_req_in           = req_payload;
      s1_req_in.digest_w0 = req_payload.digest_w0 & dmq_pkg::word_mask(0);
      s1_req_in.digest_w1 = req_payload.digest_w1 & dmq_pkg::word_mask(1);
      s1_req_in.digest_w2 = req_payload.digest_w2 & dmq_pkg::word_mask(2);
      s1_req_in.digest_w3 = req_payload.digest_w3 & dmq_pkg::word_mask(3);
   end

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold unless loaded.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= s1_req_in;
      end
      if (step) begin
         rsp_ff <= rsp_next;
      end
   end

   dmq_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (s1_req_ff),
      .rsp   (rsp_next)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A held request must not vanish while the response side is stalled.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("input stage lost a request while stalled");

   // Only a refused start reports not accepted, and it carries a refusal code.
   a_refuse_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.accepted |->
         (rsp_payload.result_code == dmq_pkg::CODE_QUAR) ||
         (rsp_payload.result_code == dmq_pkg::CODE_INVALID))
      else $error("refused request without refusal code");

   // Animation mode always has an asset kind.
   a_anim_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.mode_now == dmq_pkg::MODE_ANIM) |->
         (rsp_payload.kind_now != 2'd0))
      else $error("animation mode with no asset kind");

   // A failure code reported outside maintenance mode always comes with no asset.
   a_fail_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_payload.result_code == dmq_pkg::CODE_WDOG) ||
         (rsp_payload.result_code == dmq_pkg::CODE_RENDER)) &&
         (rsp_payload.mode_now != dmq_pkg::MODE_MAINT) |->
         (rsp_payload.kind_now == 2'd0))
      else $error("failure left an active asset");

endmodule

// File: hw/rtl/dmq_match.sv
module dmq_match (
   input  dmq_pkg::digest_type offered,
   input  dmq_pkg::digest_type held,
   output logic                equal
);

   // Full-width parallel compare; masked bits are zero on both sides.
   assign equal = (offered == held);

endmodule

// File: hw/rtl/dmq_core.sv
module dmq_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  dmq_pkg::req_type item,
   output dmq_pkg::rsp_type rsp
);

   dmq_pkg::mode_type   mode_ff, mode_in;
   dmq_pkg::mode_type   saved_ff, saved_in;
   logic [1:0]          kind_ff, kind_in;
   dmq_pkg::digest_type act_ff, act_in;
   dmq_pkg::digest_type qh_ff, qh_in;
   logic                qf_ff, qf_in;
   logic [7:0]          wd_ff, wd_in;
   dmq_pkg::code_type   code_ff, code_in;

   dmq_pkg::digest_type offered;
   logic                q_equal;
   logic                q_hit;
   logic                refuse;

   assign offered = {item.digest_w3, item.digest_w2, item.digest_w1, item.digest_w0};

   dmq_match u_match (
      .offered (offered),
      .held    (qh_ff),
      .equal   (q_equal)
   );

   assign q_hit  = qf_ff && q_equal;
   assign refuse = (item.asset_kind == 2'd0) || q_hit;

   // Next state.
   always_comb begin
      mode_in  = mode_ff;
      saved_in = saved_ff;
      kind_in  = kind_ff;
      act_in   = act_ff;
      qh_in    = qh_ff;
      qf_in    = qf_ff;
      wd_in    = wd_ff;
      code_in  = code_ff;
      case (item.op)
         dmq_pkg::OP_HOST_FRAME: begin
            mode_in = dmq_pkg::MODE_HOST;
            kind_in = 2'd0;
            code_in = dmq_pkg::CODE_OK;
         end
         dmq_pkg::OP_MAINT_BEGIN: begin
            if (mode_ff != dmq_pkg::MODE_MAINT) begin
               saved_in = mode_ff;
               mode_in  = dmq_pkg::MODE_MAINT;
            end
         end
         dmq_pkg::OP_MAINT_END: begin
            if (mode_ff == dmq_pkg::MODE_MAINT) begin
               mode_in = saved_ff;
            end
         end
         dmq_pkg::OP_ANIM_START: begin
            if (refuse) begin
               code_in = qf_ff ? dmq_pkg::CODE_QUAR : dmq_pkg::CODE_INVALID;
            end else begin
               act_in  = offered;
               kind_in = item.asset_kind;
               mode_in = dmq_pkg::MODE_ANIM;
               code_in = dmq_pkg::CODE_OK;
            end
         end
         dmq_pkg::OP_ANIM_STOP: begin
            mode_in = dmq_pkg::MODE_FALLBACK;
            kind_in = 2'd0;
            code_in = dmq_pkg::CODE_OK;
         end
         dmq_pkg::OP_FAIL: begin
            if (mode_ff == dmq_pkg::MODE_ANIM) begin
               qh_in = act_ff;
               qf_in = 1'b1;
            end
            if (item.is_watchdog && (wd_ff != dmq_pkg::WD_MAX)) begin
               wd_in = wd_ff + 8'd1;
            end
            mode_in = dmq_pkg::MODE_FALLBACK;
            kind_in = 2'd0;
            code_in = item.is_watchdog ? dmq_pkg::CODE_WDOG : dmq_pkg::CODE_RENDER;
         end
         dmq_pkg::OP_REINSTALLED: begin
            if (q_hit) begin
               qf_in = 1'b0;
            end
         end
         dmq_pkg::OP_RESTORE_Q: begin
            qh_in   = offered;
            qf_in   = 1'b1;
            mode_in = dmq_pkg::MODE_FALLBACK;
            kind_in = 2'd0;
            code_in = dmq_pkg::CODE_QUAR;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // Result fields reflect the state after the request.
   always_comb begin
      rsp.accepted       = !((item.op == dmq_pkg::OP_ANIM_START) && refuse);
      rsp.mode_now       = mode_in;
      rsp.kind_now       = kind_in;
      rsp.is_quarantined = qf_in;
      rsp.watchdog_total = wd_in;
      rsp.result_code    = code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= dmq_pkg::MODE_FALLBACK;
         saved_ff <= dmq_pkg::MODE_FALLBACK;
         kind_ff  <= 2'd0;
         qf_ff    <= 1'b0;
         wd_ff    <= 8'd0;
         code_ff  <= dmq_pkg::CODE_OK;
      end else if (step) begin
         mode_ff  <= mode_in;
         saved_ff <= saved_in;
         kind_ff  <= kind_in;
         qf_ff    <= qf_in;
         wd_ff    <= wd_in;
         code_ff  <= code_in;
      end
   end

   // Digests are only read while a flag or the animation mode vouches for them.
   always_ff @(posedge clock) begin
      if (step) begin
         act_ff <= act_in;
         qh_ff  <= qh_in;
      end
   end

endmodule
